// ===== hw/rtl/bhpq_pkg.sv =====
// shared types and constants of the binary heap priority queue
// used by bhpq_ctrl, bhpq_dp and the top level; depends on nothing

package bhpq_pkg;

    // default sizes of the store and of the entry fields
    localparam int DEPTH_DEF     = 64;
    localparam int KEY_WIDTH_DEF = 32;
    localparam int TAG_WIDTH_DEF = 16;

    // operation codes of an input word
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_FIRST = 2'd0;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_LOAD,
        S_POP_CHK,
        S_POP_CMP,
        S_FINISH
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    latch_status;
        t_status status;
        logic    push_start;
        logic    pop_start;
        logic    read_parent;
        logic    move_parent;
        logic    load_mov;
        logic    read_children;
        logic    move_child;
        logic    write_mov;
        logic    emit;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_after;
        logic has_left;
        logic child_after;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/bhpq_ctrl.sv =====
// sequencer of the heap queue: accepts words and steps the sift loops
// depends on bhpq_pkg; drives the datapath through bhpq_pkg::t_cmd

module bhpq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_opcode,
    output logic                o_stall,
    input  bhpq_pkg::t_dp_stat  i_stat,
    output bhpq_pkg::t_cmd      o_cmd
);

    bhpq_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bhpq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // input is taken only between operations
    assign o_stall = (r_state != bhpq_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = bhpq_pkg::ST_DONE;
        unique case (r_state)
            bhpq_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_status = 1'b1;
                    n_state = bhpq_pkg::S_FINISH;
                    unique case (i_opcode)
                        bhpq_pkg::OP_PUSH: begin
                            if (i_stat.full) begin
                                o_cmd.status = bhpq_pkg::ST_FULL;
                            end else begin
                                o_cmd.push_start = 1'b1;
                                n_state = bhpq_pkg::S_PUSH_CHK;
                            end
                        end
                        bhpq_pkg::OP_POP: begin
                            if (i_stat.empty) begin
                                o_cmd.status = bhpq_pkg::ST_EMPTY;
                            end else begin
                                o_cmd.pop_start = 1'b1;
                                n_state = bhpq_pkg::S_POP_LOAD;
                            end
                        end
                        default: begin
                            o_cmd.status = bhpq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            // sift up: write at the root, or fetch parent of the hole
            bhpq_pkg::S_PUSH_CHK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.write_mov = 1'b1;
                    n_state = bhpq_pkg::S_FINISH;
                end else begin
                    o_cmd.read_parent = 1'b1;
                    n_state = bhpq_pkg::S_PUSH_CMP;
                end
            end
            // sift up: move parent down or settle
            bhpq_pkg::S_PUSH_CMP: begin
                if (i_stat.parent_after) begin
                    o_cmd.move_parent = 1'b1;
                    n_state = bhpq_pkg::S_PUSH_CHK;
                end else begin
                    o_cmd.write_mov = 1'b1;
                    n_state = bhpq_pkg::S_FINISH;
                end
            end
            // last entry arrives from the store
            bhpq_pkg::S_POP_LOAD: begin
                o_cmd.load_mov = 1'b1;
                n_state = bhpq_pkg::S_POP_CHK;
            end
            // sift down: fetch children of the hole, or settle if it has none
            bhpq_pkg::S_POP_CHK: begin
                if (i_stat.has_left) begin
                    o_cmd.read_children = 1'b1;
                    n_state = bhpq_pkg::S_POP_CMP;
                end else begin
                    o_cmd.write_mov = 1'b1;
                    n_state = bhpq_pkg::S_FINISH;
                end
            end
            // sift down: move chosen child up or settle
            bhpq_pkg::S_POP_CMP: begin
                if (i_stat.child_after) begin
                    o_cmd.move_child = 1'b1;
                    n_state = bhpq_pkg::S_POP_CHK;
                end else begin
                    o_cmd.write_mov = 1'b1;
                    n_state = bhpq_pkg::S_FINISH;
                end
            end
            // hand result to the output register once it is free
            bhpq_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = bhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bhpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bhpq_dp.sv =====
// datapath of the heap queue: entry store, count, hole index, compare and output word
// depends on bhpq_pkg; sequenced by bhpq_ctrl

module bhpq_dp #(
    parameter int DEPTH     = bhpq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_max_first,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic [TAG_WIDTH-1:0]          i_tag,
    input  bhpq_pkg::t_cmd                i_cmd,
    output bhpq_pkg::t_dp_stat            o_stat,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_head_valid,
    output logic [KEY_WIDTH-1:0]          o_head_key,
    output logic [TAG_WIDTH-1:0]          o_head_tag,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int LW = AW + 1;
    localparam int EW = KEY_WIDTH + TAG_WIDTH;

    // true when key a must come out strictly after key b
    function automatic logic orders_after(input logic max_first,
                                          input logic [KEY_WIDTH-1:0] a,
                                          input logic [KEY_WIDTH-1:0] b);
        return max_first ? (a < b) : (a > b);
    endfunction

    logic [EW-1:0]   r_mem [DEPTH];
    logic [EW-1:0]   r_rd_a, r_rd_b;
    logic [EW-1:0]   r_mov;
    logic [EW-1:0]   r_head;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   r_pos;
    logic            r_has_right;
    bhpq_pkg::t_status r_status;

    logic            r_out_valid;
    logic [1:0]      r_out_status;
    logic            r_out_head_valid;
    logic [EW-1:0]   r_out_head;
    logic [CW-1:0]   r_out_count;

    logic [CW-1:0]   w_last;
    logic [LW-1:0]   w_left, w_right, w_count_ext;
    logic            w_has_left, w_has_right, w_take_right;
    logic [EW-1:0]   w_pick;
    logic [AW-1:0]   w_pick_idx;
    logic [AW-1:0]   w_addr_a;
    logic            w_wr_en;
    logic [EW-1:0]   w_wr_data;

    // child indexes of the hole; the root has the single child 1
    assign w_last      = r_count - CW'(1);
    assign w_count_ext = LW'(r_count);
    assign w_left      = (r_pos == '0) ? LW'(1) : {r_pos, 1'b0};
    assign w_right     = w_left + LW'(1);
    assign w_has_left  = (w_left < w_count_ext);
    assign w_has_right = (r_pos != '0) && (w_right < w_count_ext);

    // child that orders first, left wins ties
    assign w_take_right = r_has_right &&
        orders_after(i_max_first, r_rd_a[EW-1:TAG_WIDTH], r_rd_b[EW-1:TAG_WIDTH]);
    assign w_pick     = w_take_right ? r_rd_b : r_rd_a;
    assign w_pick_idx = w_take_right ? w_right[AW-1:0] : w_left[AW-1:0];

    // status back to the controller
    assign o_stat.full         = (r_count == CW'(DEPTH));
    assign o_stat.empty        = (r_count == '0);
    assign o_stat.pos_zero     = (r_pos == '0);
    assign o_stat.parent_after =
        orders_after(i_max_first, r_rd_a[EW-1:TAG_WIDTH], r_mov[EW-1:TAG_WIDTH]);
    assign o_stat.has_left     = w_has_left;
    assign o_stat.child_after  =
        orders_after(i_max_first, r_mov[EW-1:TAG_WIDTH], w_pick[EW-1:TAG_WIDTH]);
    assign o_stat.out_free     = !r_out_valid || !i_stall;

    // read address of port a
    always_comb begin
        if (i_cmd.pop_start) begin
            w_addr_a = w_last[AW-1:0];
        end else if (i_cmd.read_parent) begin
            w_addr_a = r_pos >> 1;
        end else begin
            w_addr_a = w_left[AW-1:0];
        end
    end

    // write port: always at the hole
    assign w_wr_en   = i_cmd.move_parent | i_cmd.move_child | i_cmd.write_mov;
    always_comb begin
        if (i_cmd.move_parent) begin
            w_wr_data = r_rd_a;
        end else if (i_cmd.move_child) begin
            w_wr_data = w_pick;
        end else begin
            w_wr_data = r_mov;
        end
    end

    // entry store, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_pos] <= w_wr_data;
        end
        if (i_cmd.pop_start || i_cmd.read_parent || i_cmd.read_children) begin
            r_rd_a <= r_mem[w_addr_a];
        end
        if (i_cmd.read_children) begin
            r_rd_b <= r_mem[w_right[AW-1:0]];
        end
    end

    // copy of the root entry
    always_ff @(posedge i_clk) begin
        if (w_wr_en && (r_pos == '0)) begin
            r_head <= w_wr_data;
        end
    end

    // count, hole index and moving entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push_start) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop_start) begin
            r_count <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_status) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.push_start) begin
            r_pos <= r_count[AW-1:0];
            r_mov <= {i_key, i_tag};
        end else if (i_cmd.pop_start) begin
            r_pos <= '0;
        end else if (i_cmd.move_parent) begin
            r_pos <= r_pos >> 1;
        end else if (i_cmd.move_child) begin
            r_pos <= w_pick_idx;
        end
        if (i_cmd.load_mov) begin
            r_mov <= r_rd_a;
        end
        if (i_cmd.read_children) begin
            r_has_right <= w_has_right;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status     <= r_status;
            r_out_head_valid <= (r_count != '0);
            r_out_head       <= (r_count != '0) ? r_head : '0;
            r_out_count      <= r_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_head_valid = r_out_head_valid;
    assign o_head_key   = r_out_head[EW-1:TAG_WIDTH];
    assign o_head_tag   = r_out_head[TAG_WIDTH-1:0];
    assign o_count      = r_out_count;

endmodule

// ===== hw/rtl/binary_heap_priority_queue_unit.sv =====
// Binary heap priority queue of key and tag entries, min or max order.
// Input channel: i_valid / o_stall with i_opcode (push, pop, query), i_key, i_tag.
// A word is taken when i_valid is high and o_stall low; o_stall is high while an
// operation runs, so one operation is in flight at a time.
// Output channel: o_valid / i_stall, one word per operation with status, head entry
// and count after the operation. The word sits in an output register; a stalled
// receiver holds it, and the next operation runs meanwhile and waits at its end.
// Steps: a push sifts up, reading the parent of the hole and then comparing and
// moving it down or writing the new entry; a pop loads the last entry and sifts
// down, reading both children and then moving the chosen child up or settling.
// The sift loops read, compare and write the single entry store. The next word
// is taken at the same edge where the result can first be taken.
// Order is set by max_first at APB address 0 (0 smallest key first, 1 largest);
// the user is to write it only while idle, which the block leaves unchecked.
// Reset (i_rst_n low at a clock edge) empties the queue, drops any pending output
// word and clears max_first; the store contents are not cleared.
// depends on bhpq_pkg, bhpq_ctrl and bhpq_dp

module binary_heap_priority_queue_unit #(
    parameter int DEPTH     = bhpq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = bhpq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = bhpq_pkg::TAG_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_opcode,
    input  logic [KEY_WIDTH-1:0]          i_key,
    input  logic [TAG_WIDTH-1:0]          i_tag,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic                          o_head_valid,
    output logic [KEY_WIDTH-1:0]          o_head_key,
    output logic [TAG_WIDTH-1:0]          o_head_tag,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic               r_max_first;
    bhpq_pkg::t_cmd     w_cmd;
    bhpq_pkg::t_dp_stat w_stat;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_first <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == bhpq_pkg::REG_MAX_FIRST)) begin
            r_max_first <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            bhpq_pkg::REG_MAX_FIRST: prdata = {31'd0, r_max_first};
            default:                 prdata = '0;
        endcase
    end

    // sequencer
    bhpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd)
    );

    // store and compare
    bhpq_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .TAG_WIDTH (TAG_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_max_first  (r_max_first),
        .i_key        (i_key),
        .i_tag        (i_tag),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_head_valid (o_head_valid),
        .o_head_key   (o_head_key),
        .o_head_tag   (o_head_tag),
        .o_count      (o_count)
    );

endmodule
